// ----- sv/adtsd_pkg.sv -----
// Package with the shared types and constants of the ADTS deframer.
`default_nettype none

package adtsd_pkg;

    localparam logic [1:0]  KIND_CFG = 2'd0;
    localparam logic [1:0]  KIND_HDR = 2'd1;
    localparam logic [1:0]  KIND_PAY = 2'd2;

    localparam logic [12:0] HDR_BYTES  = 13'd7;
    localparam logic [12:0] SYNC_SEEN  = 13'd2;
    localparam logic [7:0]  SYNC_BYTE  = 8'hFF;
    localparam logic [3:0]  SYNC_NIB   = 4'hF;
    localparam int          STORE_N    = 5;
    localparam logic [2:0]  STORE_BASE = 3'd2;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic        cfg;
        logic        main;
        logic [1:0]  kind;
        logic [15:0] word;
        logic [7:0]  pay;
        logic [12:0] flen;
        logic [15:0] fidx;
        logic        last;
        logic [2:0]  prof;
        logic [3:0]  fi;
        logic [2:0]  ch;
    } t_entry;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] data;
        logic [12:0] flen;
        logic [2:0]  prof;
        logic [3:0]  fi;
        logic [2:0]  ch;
        logic [15:0] fidx;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/adtsd_front.sv -----
// Front end: sync hunt, header capture and classification of each byte.
`default_nettype none

module adtsd_front
    import adtsd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_full,
    output logic            o_push,
    output t_entry          o_entry
);

    typedef enum logic [1:0] {PH_HUNT, PH_HDR, PH_PAY} t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_prev, n_prev;
    logic [12:0] r_seen, n_seen;
    logic [12:0] r_len, n_len;
    logic        r_cfg_sent, n_cfg_sent;
    logic [15:0] r_fcnt, n_fcnt;
    logic [7:0]  r_store [STORE_N];

    logic        accept;
    logic        store_wr;
    logic [2:0]  slot;
    logic [12:0] seen_inc;
    logic [12:0] hdr_len;
    logic [15:0] fidx_inc;
    logic [2:0]  prof;
    logic [3:0]  fi;
    logic [2:0]  ch;
    t_entry      entry;

    assign accept   = i_valid && !i_full;
    assign o_stall  = i_full;
    assign slot     = r_seen[2:0] - STORE_BASE;
    assign seen_inc = r_seen + 13'd1;
    assign fidx_inc = r_fcnt + 16'd1;
    assign hdr_len  = {r_store[1][1:0], r_store[2], r_store[3][7:5]};
    assign prof     = {1'b0, r_store[0][7:6]} + 3'd1;
    assign fi       = r_store[0][5:2];
    assign ch       = {r_store[0][0], r_store[1][7:6]};

    always_comb begin
        n_phase    = r_phase;
        n_prev     = r_prev;
        n_seen     = r_seen;
        n_len      = r_len;
        n_cfg_sent = r_cfg_sent;
        n_fcnt     = r_fcnt;
        store_wr   = 1'b0;

        entry.cfg  = 1'b0;
        entry.main = 1'b0;
        entry.kind = KIND_HDR;
        entry.word = {2'b00, prof, fi[3:1], fi[0], 1'b0, ch, 3'b000};
        entry.pay  = i_in_byte;
        entry.flen = hdr_len;
        entry.fidx = fidx_inc;
        entry.last = 1'b0;
        entry.prof = prof;
        entry.fi   = fi;
        entry.ch   = ch;

        unique case (r_phase)
            PH_HDR: begin
                n_seen   = seen_inc;
                store_wr = (slot < 3'(STORE_N));
                if (seen_inc >= HDR_BYTES) begin
                    if (!r_cfg_sent) begin
                        entry.cfg  = 1'b1;
                        n_cfg_sent = 1'b1;
                    end
                    if (hdr_len < HDR_BYTES) begin
                        n_phase = PH_HUNT;
                        n_prev  = i_in_byte;
                    end else begin
                        n_len      = hdr_len;
                        n_fcnt     = fidx_inc;
                        entry.main = 1'b1;
                        if (hdr_len == HDR_BYTES) begin
                            entry.last = 1'b1;
                            n_phase    = PH_HUNT;
                            n_prev     = 8'h00;
                        end else begin
                            n_phase = PH_PAY;
                        end
                    end
                end
            end
            PH_PAY: begin
                n_seen     = seen_inc;
                entry.main = 1'b1;
                entry.kind = KIND_PAY;
                entry.flen = r_len;
                entry.fidx = r_fcnt;
                entry.last = (seen_inc >= r_len);
                if (seen_inc >= r_len) begin
                    n_phase = PH_HUNT;
                    n_prev  = 8'h00;
                end
            end
            default: begin
                if (r_prev == SYNC_BYTE && i_in_byte[7:4] == SYNC_NIB) begin
                    n_phase = PH_HDR;
                    n_seen  = SYNC_SEEN;
                    n_prev  = 8'h00;
                end else begin
                    n_phase = PH_HUNT;
                    n_prev  = i_in_byte;
                end
            end
        endcase
    end

    assign o_push  = accept && (entry.cfg || entry.main);
    assign o_entry = entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_prev     <= 8'h00;
            r_seen     <= 13'd0;
            r_len      <= 13'd0;
            r_cfg_sent <= 1'b0;
            r_fcnt     <= 16'd0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_prev     <= n_prev;
            r_seen     <= n_seen;
            r_len      <= n_len;
            r_cfg_sent <= n_cfg_sent;
            r_fcnt     <= n_fcnt;
            if (store_wr) begin
                r_store[slot] <= i_in_byte;
            end
        end
    end

    a_pay_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAY |-> r_len > HDR_BYTES)
        else $error("payload phase with a frame length of seven or less");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("push into a full queue");

    a_hdr_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HDR |-> (r_seen >= SYNC_SEEN && r_seen < HDR_BYTES))
        else $error("header byte count out of range");

endmodule

`default_nettype wire

// ----- sv/adtsd_queue.sv -----
// Short queue of classified words between the front and back ends.
`default_nettype none

module adtsd_queue
    import adtsd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_head_valid,
    output t_entry      o_head
);

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_AW:0]   r_count;

    assign o_full       = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wr] <= i_entry;
                r_wr        <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/adtsd_back.sv -----
// Back end: expands queued words into results and holds the output register.
`default_nettype none

module adtsd_back
    import adtsd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_head_valid,
    input  wire t_entry i_head,
    output logic        o_pop,
    input  wire logic   i_stall,
    output logic        o_valid,
    output t_result     o_res
);

    logic    r_valid, n_valid;
    logic    r_sub, n_sub;
    t_result r_res, n_res;
    logic    load;

    assign load = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid && i_stall;
        n_sub   = r_sub;
        n_res   = r_res;
        o_pop   = 1'b0;
        if (load && i_head_valid) begin
            n_valid    = 1'b1;
            n_res.prof = i_head.prof;
            n_res.fi   = i_head.fi;
            n_res.ch   = i_head.ch;
            if (i_head.cfg && !r_sub) begin
                n_res.kind = KIND_CFG;
                n_res.data = i_head.word;
                n_res.flen = 13'd0;
                n_res.fidx = 16'd0;
                n_res.last = 1'b0;
                if (i_head.main) begin
                    n_sub = 1'b1;
                end else begin
                    o_pop = 1'b1;
                end
            end else begin
                n_res.kind = i_head.kind;
                n_res.data = (i_head.kind == KIND_PAY) ? {8'h00, i_head.pay} : 16'd0;
                n_res.flen = i_head.flen;
                n_res.fidx = i_head.fidx;
                n_res.last = i_head.last;
                n_sub      = 1'b0;
                o_pop      = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_sub_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (i_head_valid && i_head.cfg && i_head.main))
        else $error("split word without a matching queue head");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_head_valid)
        else $error("pop from an empty queue");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_res.kind == KIND_CFG || r_res.kind == KIND_HDR ||
                     r_res.kind == KIND_PAY))
        else $error("result with an unused kind code");

    a_cfg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.kind == KIND_CFG) |->
            (r_res.flen == 13'd0 && r_res.fidx == 16'd0 && !r_res.last))
        else $error("config result with header fields set");

endmodule

`default_nettype wire

// ----- sv/adts_frame_deframer_unit.sv -----
// Top level of the ADTS deframer: front end, word queue and back end.
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_stall    i_in_byte
//   output    out        o_valid / i_stall    o_kind .. o_last_of_frame
//
// One byte is accepted per cycle while the queue has room.
// Each result passes through the word queue and then the output register.
// The back end sends one result per cycle while the output is not stalled; the first
// complete header after reset also yields a config word, which the four-word queue absorbs.
// Reset is synchronous and active low; no clearing pass is needed.
// A stall on the output holds the output register and fills the queue,
// after which o_stall rises.
`default_nettype none

module adts_frame_deframer_unit
    import adtsd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_kind,
    output logic [15:0]      o_data_value,
    output logic [12:0]      o_frm_len,
    output logic [2:0]       o_profile,
    output logic [3:0]       o_freq_index,
    output logic [2:0]       o_channel_config,
    output logic [15:0]      o_frame_index,
    output logic             o_last_of_frame
);

    logic    push, pop, full, head_valid;
    t_entry  entry, head;
    t_result res;

    adtsd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_in_byte (i_in_byte),
        .i_full    (full),
        .o_push    (push),
        .o_entry   (entry)
    );

    adtsd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (entry),
        .i_pop        (pop),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    adtsd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_res        (res)
    );

    assign o_kind           = res.kind;
    assign o_data_value     = res.data;
    assign o_frm_len        = res.flen;
    assign o_profile        = res.prof;
    assign o_freq_index     = res.fi;
    assign o_channel_config = res.ch;
    assign o_frame_index    = res.fidx;
    assign o_last_of_frame  = res.last;

endmodule

`default_nettype wire

// ----- tb/adts_frame_deframer_checker.sv -----
// Checker for the ADTS deframer: predicts every result from the accepted bytes and compares.
`timescale 1ns / 1ps

module adts_frame_deframer_checker
    import adtsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_data_value,
    input  logic [12:0] i_frm_len,
    input  logic [2:0]  i_profile,
    input  logic [3:0]  i_freq_index,
    input  logic [2:0]  i_channel_config,
    input  logic [15:0] i_frame_index,
    input  logic        i_last_of_frame,
    output int          o_fail_count,
    output int          o_pending
);

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    t_phase      phase;
    logic [7:0]  prev_byte;
    logic [7:0]  hdr_store [0:STORE_N-1];
    logic [12:0] bytes_seen;
    logic [12:0] cur_len;
    logic        cfg_sent;
    logic [15:0] frame_cnt;
    t_result     expected_results [$];

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
        o_fail_count++;
    endtask

    function automatic t_result make_result(input logic [1:0] kind, input logic [15:0] data,
                                            input logic [12:0] flen, input logic [15:0] fidx,
                                            input logic last);
        t_result r;
        r.kind = kind;
        r.data = data;
        r.flen = flen;
        r.prof = {1'b0, hdr_store[0][7:6]} + 3'd1;
        r.fi   = hdr_store[0][5:2];
        r.ch   = {hdr_store[0][0], hdr_store[1][7:6]};
        r.fidx = fidx;
        r.last = last;
        return r;
    endfunction

    task automatic parse_byte(input logic [7:0] b);
        int          idx;
        logic [12:0] len;
        logic        last;
        t_result     cfg;
        case (phase)
            PH_HEADER: begin
                idx = int'(bytes_seen) - int'(SYNC_SEEN);
                hdr_store[idx] = b;
                bytes_seen = bytes_seen + 13'd1;
                if (bytes_seen >= HDR_BYTES) begin
                    len = {hdr_store[1][1:0], hdr_store[2], hdr_store[3][7:5]};
                    if (!cfg_sent) begin
                        cfg = make_result(KIND_CFG, 16'd0, 13'd0, 16'd0, 1'b0);
                        cfg.data = {2'b00, cfg.prof, cfg.fi, 1'b0, cfg.ch, 3'b000};
                        expected_results.push_back(cfg);
                        cfg_sent = 1'b1;
                    end
                    if (len < HDR_BYTES) begin
                        phase = PH_HUNT;
                        prev_byte = b;
                    end else begin
                        cur_len = len;
                        frame_cnt = frame_cnt + 16'd1;
                        expected_results.push_back(make_result(KIND_HDR, 16'd0, len, frame_cnt,
                                                               len == HDR_BYTES));
                        if (len == HDR_BYTES) begin
                            phase = PH_HUNT;
                            prev_byte = 8'h00;
                        end else begin
                            phase = PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                bytes_seen = bytes_seen + 13'd1;
                last = (bytes_seen >= cur_len);
                expected_results.push_back(make_result(KIND_PAY, {8'h00, b}, cur_len,
                                                       frame_cnt, last));
                if (last) begin
                    phase = PH_HUNT;
                    prev_byte = 8'h00;
                end
            end
            default: begin
                if (prev_byte == SYNC_BYTE && b[7:4] == SYNC_NIB) begin
                    phase = PH_HEADER;
                    bytes_seen = SYNC_SEEN;
                    prev_byte = 8'h00;
                end else begin
                    phase = PH_HUNT;
                    prev_byte = b;
                end
            end
        endcase
    endtask

    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            report("unexpected word, kind", {14'd0, i_kind}, 16'd0);
        end else begin
            want = expected_results.pop_front();
            if (i_kind !== want.kind) report("kind", {14'd0, i_kind}, {14'd0, want.kind});
            if (i_data_value !== want.data) report("data_value", i_data_value, want.data);
            if (i_frm_len !== want.flen) begin
                report("frm_len", {3'd0, i_frm_len}, {3'd0, want.flen});
            end
            if (i_profile !== want.prof) report("profile", {13'd0, i_profile}, {13'd0, want.prof});
            if (i_freq_index !== want.fi) begin
                report("freq_index", {12'd0, i_freq_index}, {12'd0, want.fi});
            end
            if (i_channel_config !== want.ch) begin
                report("channel_config", {13'd0, i_channel_config}, {13'd0, want.ch});
            end
            if (i_frame_index !== want.fidx) report("frame_index", i_frame_index, want.fidx);
            if (i_last_of_frame !== want.last) begin
                report("last_of_frame", {15'd0, i_last_of_frame}, {15'd0, want.last});
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase = PH_HUNT;
            prev_byte = 8'h00;
            for (int i = 0; i < STORE_N; i++) hdr_store[i] = 8'h00;
            bytes_seen = 13'd0;
            cur_len = 13'd0;
            cfg_sent = 1'b0;
            frame_cnt = 16'd0;
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) check_result();
            if (i_in_valid && !i_in_stall) parse_byte(i_in_byte);
        end
        o_pending = expected_results.size();
    end

endmodule

// ----- tb/adts_frame_deframer_unit_tb.sv -----
// Testbench top for the ADTS deframer: clock, reset, byte stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module adts_frame_deframer_unit_tb;
    import adtsd_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_in_byte;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_kind;
    logic [15:0] o_data_value;
    logic [12:0] o_frm_len;
    logic [2:0]  o_profile;
    logic [3:0]  o_freq_index;
    logic [2:0]  o_channel_config;
    logic [15:0] o_frame_index;
    logic        o_last_of_frame;
    int          fail_count;
    int          pending;

    int in_left  = 0;
    bit in_calm  = 1'b0;
    int out_left = 0;
    bit out_calm = 1'b0;
    int sent     = 0;

    adts_frame_deframer_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_in_byte        (i_in_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_data_value     (o_data_value),
        .o_frm_len        (o_frm_len),
        .o_profile        (o_profile),
        .o_freq_index     (o_freq_index),
        .o_channel_config (o_channel_config),
        .o_frame_index    (o_frame_index),
        .o_last_of_frame  (o_last_of_frame)
    );

    adts_frame_deframer_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_in_byte        (i_in_byte),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_kind           (o_kind),
        .i_data_value     (o_data_value),
        .i_frm_len        (o_frm_len),
        .i_profile        (o_profile),
        .i_freq_index     (o_freq_index),
        .i_channel_config (o_channel_config),
        .i_frame_index    (o_frame_index),
        .i_last_of_frame  (o_last_of_frame),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Gaps come in stretches, some of which have no idling at all.
    function automatic int draw_gap(inout int left, inout bit calm);
        if (left == 0) begin
            left = $urandom_range(20, 80);
            calm = ($urandom_range(0, 3) == 0);
        end
        left--;
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap(in_left, in_calm);
        sent++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_header(input logic [12:0] len, input logic [7:0] last_byte,
                               input bit skip_ff);
        logic [31:0] rnd;
        rnd = $urandom;
        if (!skip_ff) send_byte(SYNC_BYTE);
        send_byte({SYNC_NIB, rnd[3:0]});
        send_byte(rnd[11:4]);
        send_byte({rnd[17:12], len[12:11]});
        send_byte(len[10:3]);
        send_byte({len[2:0], rnd[22:18]});
        send_byte(last_byte);
    endtask

    task automatic send_payload(input int n);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
    endtask

    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            n = draw_gap(out_left, out_calm);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        int sel;
        int len;
        logic [7:0] rb;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in_byte = 8'h00;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_byte(8'h00);
        send_byte(SYNC_BYTE);
        send_byte(8'h7F);
        send_byte(8'h55);
        // The first header is too short: config word, then a false sync that leaves 0xFF behind.
        send_header(13'd3, SYNC_BYTE, 1'b1 == 1'b0);
        send_header(13'd7, 8'h00, 1'b1);
        send_header(13'd8, 8'h12, 1'b0);
        send_byte(SYNC_BYTE);
        send_byte(8'hF1);
        send_header(13'd0, 8'h00, 1'b0);
        send_header(13'd10, SYNC_BYTE, 1'b0);
        send_byte(SYNC_BYTE);
        send_byte(8'hF3);
        send_byte(8'h00);
        send_header(13'd7, 8'hA5, 1'b0);

        while (sent < 700) begin
            sel = $urandom_range(0, 19);
            if (sel < 14) begin
                if ($urandom_range(0, 9) == 0) begin
                    len = $urandom_range(7, 120);
                end else begin
                    len = $urandom_range(7, 24);
                end
                send_header(13'(len), 8'($urandom_range(0, 255)), 1'b0);
                send_payload(len - 7);
            end else if (sel < 16) begin
                send_header(13'($urandom_range(0, 6)), 8'($urandom_range(0, 255)), 1'b0);
            end else if (sel < 18) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 254)));
            end else begin
                rb = 8'($urandom_range(0, 255));
                rb[7:4] = 4'($urandom_range(0, 14));
                send_byte(SYNC_BYTE);
                send_byte(rb);
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- adts_frame_deframer_unit.f -----
sv/adtsd_pkg.sv
sv/adtsd_front.sv
sv/adtsd_queue.sv
sv/adtsd_back.sv
sv/adts_frame_deframer_unit.sv
tb/adts_frame_deframer_checker.sv
tb/adts_frame_deframer_unit_tb.sv
